[rtl/mwfc_pkg.sv]
// ----------------------------------------------------------------------------
// mwfc_pkg
// Shared types, codes and the CRC-16 byte update of the frame checker.
// ----------------------------------------------------------------------------
package mwfc_pkg;

  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned CRC_LEN   = 6;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FN_READ   = 8'h03;
  localparam logic [7:0]  FN_WRITE  = 8'h06;
  localparam logic [15:0] REG_MOTOR = 16'h0000;

  localparam logic [7:0]  ADDR_RST  = 8'h01;
  localparam logic [15:0] MAX_RST   = 16'd255;

  // Configuration register indexes
  localparam logic CFG_DEV_ADDR = 1'b0;
  localparam logic CFG_MAX_REF  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_CRC  = CNT_W'(CRC_LEN);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ADDR     = 3'd1,
    ST_READ     = 3'd2,
    ST_FUNC     = 3'd3,
    ST_REG      = 3'd4,
    ST_RANGE    = 3'd5,
    ST_CRC      = 3'd6
  } status_t;

  // One checked frame: byte k sits at frame[k]
  typedef struct packed {
    status_t                         status;
    logic [FRAME_LEN-1:0][7:0]       frame;
  } desc_t;

  // Queue state seen by the input handshake and the back
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/mwfc_front.sv]
// ----------------------------------------------------------------------------
// mwfc_front
// Byte intake: buffers the frame, runs the CRC and classifies the frame.
// ----------------------------------------------------------------------------
module mwfc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  logic [7:0]          device_address,
  input  logic [15:0]         max_reference,
  output logic                push,
  output mwfc_pkg::desc_t     push_desc
);

  logic [mwfc_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic [15:0]                crc_r, crc_nxt, crc_eff;
  logic [7:0]                 buf_r [mwfc_pkg::FRAME_LEN];
  logic                       final_byte;
  logic [15:0]                reg_addr, value;
  mwfc_pkg::status_t          status;

  // frame_start restarts the frame with this byte as byte 0
  assign cnt_eff    = frame_start ? '0 : cnt_r;
  assign crc_eff    = frame_start ? mwfc_pkg::CRC_INIT : crc_r;
  assign final_byte = (cnt_eff == mwfc_pkg::CNT_LAST);

  always_comb begin
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    if (accept) begin
      if (final_byte) begin
        cnt_nxt = '0;
        crc_nxt = mwfc_pkg::CRC_INIT;
      end else begin
        cnt_nxt = cnt_eff + 1'b1;
        crc_nxt = (cnt_eff < mwfc_pkg::CNT_CRC) ? mwfc_pkg::crc_byte(crc_eff, rx_byte)
                                                : crc_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      crc_r <= mwfc_pkg::CRC_INIT;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r[cnt_eff] <= rx_byte;
    end
  end

  // Checks in priority order; the last byte comes straight from the input
  assign reg_addr = {buf_r[2], buf_r[3]};
  assign value    = {buf_r[4], buf_r[5]};

  always_comb begin
    if (buf_r[0] != device_address) begin
      status = mwfc_pkg::ST_ADDR;
    end else if (buf_r[1] == mwfc_pkg::FN_READ) begin
      status = mwfc_pkg::ST_READ;
    end else if (buf_r[1] != mwfc_pkg::FN_WRITE) begin
      status = mwfc_pkg::ST_FUNC;
    end else if (reg_addr != mwfc_pkg::REG_MOTOR) begin
      status = mwfc_pkg::ST_REG;
    end else if (value > max_reference) begin
      status = mwfc_pkg::ST_RANGE;
    end else if (buf_r[6] != crc_r[15:8] || rx_byte != crc_r[7:0]) begin
      status = mwfc_pkg::ST_CRC;
    end else begin
      status = mwfc_pkg::ST_OK;
    end
  end

  always_comb begin
    push_desc.status = status;
    for (int k = 0; k < mwfc_pkg::FRAME_LEN - 1; k++) begin
      push_desc.frame[k] = buf_r[k];
    end
    push_desc.frame[mwfc_pkg::FRAME_LEN-1] = rx_byte;
  end

  assign push = accept && final_byte;

endmodule

[rtl/mwfc_queue.sv]
// ----------------------------------------------------------------------------
// mwfc_queue
// Two-entry queue of checked frames between intake and result output.
// ----------------------------------------------------------------------------
module mwfc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mwfc_pkg::desc_t     push_desc,
  input  logic                pop,
  output mwfc_pkg::desc_t     head,
  output mwfc_pkg::q_stat_t   stat
);

  mwfc_pkg::desc_t ent_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.valid = (cnt_r != 2'd0);
  assign stat.full  = cnt_r[1];

endmodule

[rtl/mwfc_back.sv]
// ----------------------------------------------------------------------------
// mwfc_back
// Result output: turns each checked frame into a status or eight echoes.
// ----------------------------------------------------------------------------
module mwfc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mwfc_pkg::desc_t     head,
  input  mwfc_pkg::q_stat_t   stat,
  output logic                pop,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [7:0]          tx_byte,
  output logic                echo_valid,
  output logic                last,
  output mwfc_pkg::status_t   status,
  output logic [15:0]         reference,
  output logic                go
);

  logic [mwfc_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [15:0]                ref_r, ref_nxt;
  logic                       vld_r, vld_nxt;
  logic                       slot_free, emit, accepted, fin;
  logic [15:0]                head_val;

  logic [7:0]                 tx_r, tx_nxt;
  logic                       ev_r, ev_nxt, last_r, last_nxt, go_r, go_nxt;
  mwfc_pkg::status_t          st_r, st_nxt;
  logic [15:0]                oref_r, oref_nxt;

  assign slot_free = !vld_r || out_tready;
  assign emit      = slot_free && stat.valid;
  assign accepted  = (head.status == mwfc_pkg::ST_OK);
  assign head_val  = {head.frame[4], head.frame[5]};
  assign fin       = !accepted || (idx_r == mwfc_pkg::CNT_LAST);
  assign pop       = emit && fin;

  always_comb begin
    idx_nxt  = idx_r;
    ref_nxt  = ref_r;
    vld_nxt  = vld_r && !out_tready;
    tx_nxt   = tx_r;
    ev_nxt   = ev_r;
    last_nxt = last_r;
    go_nxt   = go_r;
    st_nxt   = st_r;
    oref_nxt = oref_r;
    if (emit) begin
      vld_nxt  = 1'b1;
      idx_nxt  = fin ? '0 : idx_r + 1'b1;
      st_nxt   = head.status;
      last_nxt = fin;
      if (accepted) begin
        ref_nxt  = head_val;
        oref_nxt = head_val;
        tx_nxt   = head.frame[idx_r];
        ev_nxt   = 1'b1;
        go_nxt   = fin;
      end else begin
        oref_nxt = ref_r;
        tx_nxt   = 8'h00;
        ev_nxt   = 1'b0;
        go_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ref_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ref_r <= ref_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_r   <= tx_nxt;
    ev_r   <= ev_nxt;
    last_r <= last_nxt;
    go_r   <= go_nxt;
    st_r   <= st_nxt;
    oref_r <= oref_nxt;
  end

  assign out_tvalid = vld_r;
  assign tx_byte    = tx_r;
  assign echo_valid = ev_r;
  assign last       = last_r;
  assign go         = go_r;
  assign status     = st_r;
  assign reference  = oref_r;

endmodule

[rtl/modbus_write_frame_checker.sv]
// ----------------------------------------------------------------------------
// modbus_write_frame_checker
// Checks 8-byte Modbus RTU write-single-register frames and echoes them.
// ----------------------------------------------------------------------------
// Receives one frame byte per request on the input stream (frame_start in
// in_tuser realigns the frame so that this byte is byte 0). The CRC-16 over
// bytes 0..5 is updated one byte per cycle, so a byte is taken every cycle
// while the two-entry frame queue has room. On the eighth byte the frame is
// checked for address, function (read frames are reported and ignored),
// register 0, value limit and CRC (high byte sent first). An accepted write
// updates the stored reference and produces eight echo results, go set on
// the last; any other outcome produces a single status result with tlast.
// The output stage emits one result per cycle when out_tready is high, so
// back-to-back accepted frames run at one byte in and one byte out per
// cycle. Frames pass the queue to the output register. Configuration writes
// take effect at once and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module modbus_write_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] tx_byte, [10:8] status,
                                  // [26:11] reference, [27] go, rest zero
  output logic        out_tlast,  // last result of the frame
  output logic        out_tuser,  // [0] echo_valid
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [7:0]            dev_addr_r;
  logic [15:0]           max_ref_r;
  logic                  accept, push, pop;
  mwfc_pkg::desc_t       push_desc, head;
  mwfc_pkg::q_stat_t     q_stat;
  logic [7:0]            tx_byte;
  mwfc_pkg::status_t     status;
  logic [15:0]           reference;
  logic                  go;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= mwfc_pkg::ADDR_RST;
      max_ref_r  <= mwfc_pkg::MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mwfc_pkg::CFG_DEV_ADDR: dev_addr_r <= cfg_wdata[7:0];
        mwfc_pkg::CFG_MAX_REF:  max_ref_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold input requests only while the frame queue is full
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  mwfc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .rx_byte        (in_tdata),
    .frame_start    (in_tuser),
    .device_address (dev_addr_r),
    .max_reference  (max_ref_r),
    .push           (push),
    .push_desc      (push_desc)
  );

  mwfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  mwfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .stat       (q_stat),
    .pop        (pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .tx_byte    (tx_byte),
    .echo_valid (out_tuser),
    .last       (out_tlast),
    .status     (status),
    .reference  (reference),
    .go         (go)
  );

  assign out_tdata = {4'b0000, go, reference, status, tx_byte};

endmodule

[rtl/mwfc_checker.sv]
// ----------------------------------------------------------------------------
// mwfc_checker
// Port-level checks of the frame checker's result stream.
// ----------------------------------------------------------------------------
module mwfc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser
);

  // A status result stands alone and reports a failure
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_tdata[10:8] != mwfc_pkg::ST_OK))
    else $error("status result without tlast or with accepted code");

  // Echo results belong to accepted frames only
  a_echo_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[10:8] == mwfc_pkg::ST_OK))
    else $error("echo result with failure status");

  // go only on the final echo, and always there
  a_go_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27] == (out_tuser && out_tlast)))
    else $error("go does not match final echo");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind modbus_write_frame_checker mwfc_checker u_mwfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Modbus RTU write-frame checker.
// ----------------------------------------------------------------------------
// Feeds frame bytes on the input stream and checks every result on the output
// stream against a scoreboard. The scoreboard keeps its own copy of the frame
// buffer, byte position, running CRC-16, stored reference and both registers.
// It predicts the eight echo results of an accepted write, or the single
// status result of a rejected frame. The stimulus starts with hand-built
// frames for each check outcome, then moves to mostly well-formed random
// frames mixed with noise and cut-off frames. It runs under several register
// settings, the extremes among them. Both stream sides insert random gaps.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 10;   // cycles after the last result
  localparam int unsigned PHASE_BYTES  = 20;   // random bytes per register set

  typedef enum {CRC_GOOD, CRC_SWAPPED, CRC_FLIPPED} crc_fault_t;

  // One result as the block should present it
  typedef struct {
    logic [7:0]        tx;
    logic              echo;
    logic              last;
    mwfc_pkg::status_t status;
    logic [15:0]       ref_val;
    logic              go;
  } reply_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the frame in progress and holds the replies still due
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [7:0]  dev_addr;
    logic [15:0] max_ref;
    logic [7:0]  frame_bytes [mwfc_pkg::FRAME_LEN];
    logic [2:0]  byte_idx;
    logic [15:0] crc_acc;
    logic [15:0] motor_ref;
    reply_t      pending_replies [$];
    int          mismatches;

    function new();
      dev_addr  = mwfc_pkg::ADDR_RST;
      max_ref   = mwfc_pkg::MAX_RST;
      byte_idx  = '0;
      crc_acc   = mwfc_pkg::CRC_INIT;
      motor_ref = '0;
      mismatches = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    endfunction

    // CRC-16, reflected, one byte, LSB first
    static function logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
        if (acc[0] ^ b[i]) acc = (acc >> 1) ^ mwfc_pkg::CRC_POLY;
        else acc = acc >> 1;
      end
      return acc;
    endfunction

    function void set_register(input logic idx, input logic [15:0] value);
      if (idx == mwfc_pkg::CFG_DEV_ADDR) dev_addr = value[7:0];
      else max_ref = value;
    endfunction

    // Account for one accepted request; queue the replies of a finished frame
    task take_rx_byte(input logic [7:0] b, input logic start);
      logic [15:0]       reg_no;
      logic [15:0]       value;
      mwfc_pkg::status_t verdict;
      reply_t            r;
      if (start) begin
        byte_idx = '0;
        crc_acc  = mwfc_pkg::CRC_INIT;
      end
      frame_bytes[byte_idx] = b;
      if (byte_idx < mwfc_pkg::CRC_LEN) crc_acc = crc16_step(crc_acc, b);
      if (byte_idx != 3'(mwfc_pkg::FRAME_LEN - 1)) begin
        byte_idx = byte_idx + 3'd1;
        return;
      end

      reg_no = {frame_bytes[2], frame_bytes[3]};
      value  = {frame_bytes[4], frame_bytes[5]};
      if (frame_bytes[0] != dev_addr) verdict = mwfc_pkg::ST_ADDR;
      else if (frame_bytes[1] == mwfc_pkg::FN_READ) verdict = mwfc_pkg::ST_READ;
      else if (frame_bytes[1] != mwfc_pkg::FN_WRITE) verdict = mwfc_pkg::ST_FUNC;
      else if (reg_no != mwfc_pkg::REG_MOTOR) verdict = mwfc_pkg::ST_REG;
      else if (value > max_ref) verdict = mwfc_pkg::ST_RANGE;
      else if (frame_bytes[6] != crc_acc[15:8] || frame_bytes[7] != crc_acc[7:0])
        verdict = mwfc_pkg::ST_CRC;
      else verdict = mwfc_pkg::ST_OK;

      byte_idx = '0;
      crc_acc  = mwfc_pkg::CRC_INIT;

      if (verdict != mwfc_pkg::ST_OK) begin
        r = '{tx: 8'h00, echo: 1'b0, last: 1'b1, status: verdict, ref_val: motor_ref,
              go: 1'b0};
        pending_replies.push_back(r);
        return;
      end
      // Store the reference only once the whole frame, CRC included, passed
      motor_ref = value;
      for (int k = 0; k < mwfc_pkg::FRAME_LEN; k++) begin
        r = '{tx: frame_bytes[k], echo: 1'b1, last: (k == mwfc_pkg::FRAME_LEN - 1),
              status: mwfc_pkg::ST_OK, ref_val: motor_ref,
              go: (k == mwfc_pkg::FRAME_LEN - 1)};
        pending_replies.push_back(r);
      end
    endtask

    task report_mismatch(input string what, input int got, input int want);
      $display("tb: mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatches++;
    endtask

    task check_reply(input logic [31:0] data, input logic tlast, input logic tuser);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result", data, 0);
        return;
      end
      want = pending_replies.pop_front();
      if (data[7:0] !== want.tx) report_mismatch("tx_byte", data[7:0], want.tx);
      if (tuser !== want.echo) report_mismatch("echo_valid", tuser, want.echo);
      if (tlast !== want.last) report_mismatch("last", tlast, want.last);
      if (data[10:8] !== want.status) report_mismatch("status", data[10:8], want.status);
      if (data[26:11] !== want.ref_val)
        report_mismatch("reference", data[26:11], want.ref_val);
      if (data[27] !== want.go) report_mismatch("go", data[27], want.go);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        in_tuser;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [7:0] tx_byte, [10:8] status, [26:11] reference, [27] go
  logic        out_tlast;
  logic        out_tuser;  // [0] echo_valid
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  frame_scoreboard sb;
  bit          in_idle_on;
  bit          out_idle_on;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  modbus_write_frame_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Mostly no gap, some short, a few long
  function automatic int pick_gap(input bit enable);
    int roll;
    if (!enable) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Hold the run to a generous cycle budget
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: stall at random, check each accepted result
  initial out_tready = 1'b0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      int n;
      n = pick_gap(out_idle_on);
      out_tready <= (n == 0);
      if (n > 0) stall_left <= n - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata, out_tlast, out_tuser);
  end

  // --------------------------------------------------------------------------
  // Drivers; every task is entered and left at a falling edge
  // --------------------------------------------------------------------------
  task send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = pick_gap(in_idle_on);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    sb.take_rx_byte(b, start);
    @(negedge clk);
  endtask

  // Build a write-style frame and send its first n_bytes bytes
  task send_frame(input logic [7:0] addr, input logic [7:0] fn, input logic [15:0] reg_no,
                  input logic [15:0] value, input crc_fault_t fault, input bit mark_first,
                  input int n_bytes);
    logic [7:0]  fb [mwfc_pkg::FRAME_LEN];
    logic [15:0] crc;
    fb[0] = addr;
    fb[1] = fn;
    fb[2] = reg_no[15:8];
    fb[3] = reg_no[7:0];
    fb[4] = value[15:8];
    fb[5] = value[7:0];
    crc = mwfc_pkg::CRC_INIT;
    for (int i = 0; i < mwfc_pkg::CRC_LEN; i++)
      crc = frame_scoreboard::crc16_step(crc, fb[i]);
    // High byte goes first on this link
    case (fault)
      CRC_SWAPPED: begin
        fb[6] = crc[7:0];
        fb[7] = crc[15:8];
      end
      CRC_FLIPPED: begin
        crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        fb[6] = crc[15:8];
        fb[7] = crc[7:0];
      end
      default: begin
        fb[6] = crc[15:8];
        fb[7] = crc[7:0];
      end
    endcase
    for (int i = 0; i < n_bytes; i++) send_byte(fb[i], (i == 0) && mark_first);
  endtask

  task write_cfg(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // Drop valid, drain all due results, then let the pipeline settle
  task wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task run_directed();
    // Accepted writes at both ends of the default limit, no idling
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'h0000,
               CRC_GOOD, 1'b1, mwfc_pkg::FRAME_LEN);
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, mwfc_pkg::MAX_RST,
               CRC_GOOD, 1'b1, mwfc_pkg::FRAME_LEN);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    // Each rejection, with the reference held from the last good write
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR,
               mwfc_pkg::MAX_RST + 16'd1, CRC_GOOD, 1'b1, mwfc_pkg::FRAME_LEN);
    send_frame(8'hFF, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'h0001,
               CRC_GOOD, 1'b1, mwfc_pkg::FRAME_LEN);
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_READ, mwfc_pkg::REG_MOTOR, 16'h0001,
               CRC_GOOD, 1'b1, mwfc_pkg::FRAME_LEN);
    send_frame(mwfc_pkg::ADDR_RST, 8'hFF, mwfc_pkg::REG_MOTOR, 16'h0001,
               CRC_GOOD, 1'b1, mwfc_pkg::FRAME_LEN);
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_WRITE, 16'hFFFF, 16'h0001,
               CRC_GOOD, 1'b1, mwfc_pkg::FRAME_LEN);
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'h0012,
               CRC_SWAPPED, 1'b1, mwfc_pkg::FRAME_LEN);
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'h0012,
               CRC_FLIPPED, 1'b1, mwfc_pkg::FRAME_LEN);
    // Cut-off frame, then a fresh start realigns
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'h0034,
               CRC_GOOD, 1'b1, 3);
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'h0056,
               CRC_GOOD, 1'b1, mwfc_pkg::FRAME_LEN);
    // Aligned frame without the start mark still counts from byte 0
    send_frame(mwfc_pkg::ADDR_RST, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'h00FE,
               CRC_GOOD, 1'b0, mwfc_pkg::FRAME_LEN);
  endtask

  // Random frames, mostly well formed, some broken, some noise
  task run_random(input int unsigned n_target);
    int unsigned sent;
    int          roll;
    int          n;
    logic [7:0]  addr;
    logic [7:0]  fn;
    logic [15:0] value;
    bit          mark;
    sent = 0;
    while (sent < n_target) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      roll  = $urandom_range(0, 99);
      mark  = (sb.byte_idx != 0) || ($urandom_range(0, 4) != 0);
      addr  = sb.dev_addr;
      fn    = mwfc_pkg::FN_WRITE;
      value = (sb.max_ref == 0) ? 16'h0000 :
              ($urandom_range(0, 9) == 0) ? sb.max_ref : 16'($urandom_range(0, sb.max_ref));
      if (roll < 55) begin
        send_frame(addr, fn, mwfc_pkg::REG_MOTOR, value, CRC_GOOD, mark, mwfc_pkg::FRAME_LEN);
        sent += mwfc_pkg::FRAME_LEN;
      end else if (roll < 62) begin
        do addr = 8'($urandom_range(0, 255)); while (addr == sb.dev_addr);
        send_frame(addr, fn, mwfc_pkg::REG_MOTOR, value, CRC_GOOD, mark, mwfc_pkg::FRAME_LEN);
        sent += mwfc_pkg::FRAME_LEN;
      end else if (roll < 67) begin
        send_frame(addr, mwfc_pkg::FN_READ, 16'($urandom), 16'($urandom), CRC_GOOD, mark,
                   mwfc_pkg::FRAME_LEN);
        sent += mwfc_pkg::FRAME_LEN;
      end else if (roll < 72) begin
        do fn = 8'($urandom_range(0, 255));
        while (fn == mwfc_pkg::FN_READ || fn == mwfc_pkg::FN_WRITE);
        send_frame(addr, fn, mwfc_pkg::REG_MOTOR, value, CRC_GOOD, mark, mwfc_pkg::FRAME_LEN);
        sent += mwfc_pkg::FRAME_LEN;
      end else if (roll < 77) begin
        send_frame(addr, fn, 16'($urandom_range(1, 65535)), value, CRC_GOOD, mark,
                   mwfc_pkg::FRAME_LEN);
        sent += mwfc_pkg::FRAME_LEN;
      end else if (roll < 83) begin
        if (sb.max_ref != 16'hFFFF) value = 16'($urandom_range(sb.max_ref + 1, 65535));
        send_frame(addr, fn, mwfc_pkg::REG_MOTOR, value, CRC_GOOD, mark, mwfc_pkg::FRAME_LEN);
        sent += mwfc_pkg::FRAME_LEN;
      end else if (roll < 90) begin
        send_frame(addr, fn, mwfc_pkg::REG_MOTOR, value,
                   ($urandom_range(0, 1) != 0) ? CRC_SWAPPED : CRC_FLIPPED, mark,
                   mwfc_pkg::FRAME_LEN);
        sent += mwfc_pkg::FRAME_LEN;
      end else if (roll < 95) begin
        n = $urandom_range(1, mwfc_pkg::FRAME_LEN - 1);
        send_frame(addr, fn, mwfc_pkg::REG_MOTOR, value, CRC_GOOD, 1'b1, n);
        sent += n;
      end else begin
        // Noise, with the odd stray start mark
        n = $urandom_range(1, 10);
        repeat (n) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
        sent += n;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = mwfc_pkg::CFG_DEV_ADDR;
    cfg_wdata   = 16'h0000;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    run_random(PHASE_BYTES);
    wait_idle();

    // Lowest settings: address 0 and only a zero reference allowed
    write_cfg(mwfc_pkg::CFG_DEV_ADDR, 16'h0000);
    write_cfg(mwfc_pkg::CFG_MAX_REF, 16'h0000);
    send_frame(8'h00, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'h0000, CRC_GOOD, 1'b1,
               mwfc_pkg::FRAME_LEN);
    send_frame(8'h00, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'h0001, CRC_GOOD, 1'b1,
               mwfc_pkg::FRAME_LEN);
    run_random(PHASE_BYTES);
    wait_idle();

    // Highest settings: address 0xFF and the full reference range
    write_cfg(mwfc_pkg::CFG_DEV_ADDR, 16'h00FF);
    write_cfg(mwfc_pkg::CFG_MAX_REF, 16'hFFFF);
    send_frame(8'hFF, mwfc_pkg::FN_WRITE, mwfc_pkg::REG_MOTOR, 16'hFFFF, CRC_GOOD, 1'b1,
               mwfc_pkg::FRAME_LEN);
    run_random(PHASE_BYTES);
    wait_idle();

    // Two random settings; the upper data bits ride along on the address write
    write_cfg(mwfc_pkg::CFG_DEV_ADDR, 16'($urandom));
    write_cfg(mwfc_pkg::CFG_MAX_REF, 16'($urandom));
    run_random(PHASE_BYTES);
    wait_idle();

    write_cfg(mwfc_pkg::CFG_MAX_REF, 16'($urandom_range(0, 15)));
    write_cfg(mwfc_pkg::CFG_DEV_ADDR, 16'($urandom_range(0, 255)));
    run_random(PHASE_BYTES);
    wait_idle();

    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
